@@ hw/rtl/lru_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the LRU page frame table.
// Used by lru_cell, lru_page_replacement and lru_chk; no dependencies.
package lru_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 8;

  // Widest values the parameter ranges allow; chain structs carry these
  localparam int IDX_MAX_W  = 6;
  localparam int PAGE_MAX_W = 32;

  // Result field and register widths
  localparam int FRAME_W = 3;
  localparam int FIU_W   = 4;
  localparam logic [FIU_W-1:0] FIU_RESET = 4'd8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_FRAMES_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } lru_state_t;

  // Running result of the search, handed from cell to cell
  typedef struct packed {
    logic                  hit;
    logic [IDX_MAX_W-1:0]  hit_idx;
    logic [IDX_MAX_W-1:0]  hit_rank;
    logic                  has_empty;
    logic [IDX_MAX_W-1:0]  empty_idx;
    logic                  has_victim;
    logic [IDX_MAX_W-1:0]  victim_idx;
    logic [IDX_MAX_W-1:0]  worst;
    logic [PAGE_MAX_W-1:0] victim_page;
  } scan_t;

  // Update broadcast to every cell when a request commits
  typedef struct packed {
    logic                  en;
    logic [IDX_MAX_W-1:0]  idx;
    logic                  age_all;
    logic [IDX_MAX_W-1:0]  limit;
    logic                  fill;
    logic [PAGE_MAX_W-1:0] page;
  } upd_t;

endpackage

@@ hw/rtl/lru_cell.sv @@
`timescale 1ns / 1ps
// One page frame: page, valid bit and recency rank, plus one stage of the search chain.
// Depends on lru_pkg.
module lru_cell #(
  parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lru_pkg::PAGE_BITS_DEF,
  parameter int IDX        = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 act,       // frame is below frames_in_use
  input  logic                 clr,       // empty the frame
  input  logic [PAGE_BITS-1:0] page_req,
  input  logic                 tok_in,
  input  lru_pkg::scan_t       scan_in,
  output logic                 tok_out,
  output lru_pkg::scan_t       scan_out,
  input  lru_pkg::upd_t        upd
);

  localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int IW     = lru_pkg::IDX_MAX_W;
  localparam int PW     = lru_pkg::PAGE_MAX_W;
  localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_FRAMES - 1);
  localparam logic [IW-1:0]     MY_IDX   = IW'(IDX);

  logic                 valid_r, valid_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 tok_r;
  lru_pkg::scan_t       scan_r, scan_nxt;
  logic [IW-1:0]        rank_x;

  assign rank_x = IW'(rank_r);

  // search stage
  always_comb begin
    scan_nxt = scan_in;
    if (act) begin
      if (valid_r && page_r == page_req && !scan_in.hit) begin
        scan_nxt.hit      = 1'b1;
        scan_nxt.hit_idx  = MY_IDX;
        scan_nxt.hit_rank = rank_x;
      end
      if (!valid_r) begin
        if (!scan_in.has_empty) begin
          scan_nxt.has_empty = 1'b1;
          scan_nxt.empty_idx = MY_IDX;
        end
      end else if (!scan_in.has_victim || rank_x > scan_in.worst) begin
        scan_nxt.has_victim  = 1'b1;
        scan_nxt.victim_idx  = MY_IDX;
        scan_nxt.worst       = rank_x;
        scan_nxt.victim_page = PW'(page_r);
      end
    end
  end

  // frame state update
  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    page_nxt  = page_r;
    if (clr) begin
      valid_nxt = 1'b0;
      rank_nxt  = '0;
    end else if (upd.en) begin
      if (upd.idx == MY_IDX) begin
        rank_nxt = '0;
        if (upd.fill) begin
          valid_nxt = 1'b1;
          page_nxt  = upd.page[PAGE_BITS-1:0];
        end
      end else if (valid_r && (upd.age_all || rank_x < upd.limit) && rank_r < RANK_TOP) begin
        rank_nxt = rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
      tok_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      tok_r   <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    if (tok_in) begin
      scan_r <= scan_nxt;
    end
  end

  assign tok_out  = tok_r;
  assign scan_out = scan_r;

endmodule

@@ hw/rtl/lru_page_replacement.sv @@
`timescale 1ns / 1ps
// LRU page replacement top level: stream ports, APB register, control and cell chain.
// Depends on lru_pkg and lru_cell.
//
// Fully associative LRU page frame table. Each request beat on the in_ side
// carries a page number and yields exactly one result beat on the out_ side:
// hit flag (tuser), frame used, and the evicted page if a resident page was
// replaced. After acceptance a search token walks the chain of MAX_FRAMES
// frame cells, one cell per cycle, then the commit state updates all frames
// and loads the output register. One request is in flight at a time; the
// next one is taken while a finished result still waits in the output
// register. A result held by out_tready delays the commit, and with it the
// next request. frames_in_use (address 0x0) selects the active frames; 0
// acts as 1, values above MAX_FRAMES act as MAX_FRAMES, and every write to
// it empties all frames.
module lru_page_replacement #(
  parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lru_pkg::PAGE_BITS_DEF,
  localparam int IN_W  = ((PAGE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((lru_pkg::FRAME_W + 1 + PAGE_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_W-1:0]                in_tdata,   // [PAGE_BITS-1:0] page
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata,  // [2:0] frame, [3] evicted_valid,
                                                     // [PAGE_BITS+3:4] evicted_page
  output logic                           out_tuser,  // [0] hit
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [lru_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [lru_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [lru_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int PW  = lru_pkg::PAGE_MAX_W;
  localparam int FW  = lru_pkg::FRAME_W;

  // ---- configuration register ----
  logic [lru_pkg::FIU_W-1:0] fiu_r;
  logic                      cfg_wr;
  logic                      reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[2] == lru_pkg::REG_FRAMES_IN_USE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel;
  assign cfg_prdata = reg_sel ? lru_pkg::CFG_DATA_W'(fiu_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r <= lru_pkg::FIU_RESET;
    end else if (cfg_wr) begin
      fiu_r <= cfg_pwdata[lru_pkg::FIU_W-1:0];
    end
  end

  // Active frames: zero acts as one; indexes past MAX_FRAMES simply do not exist
  logic [MAX_FRAMES-1:0] cell_act;
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      cell_act[i] = (fiu_r == '0) ? (i == 0) : (32'(i) < 32'(fiu_r));
    end
  end

  // ---- control ----
  lru_pkg::lru_state_t  state_r, state_nxt;
  logic                 start_r;
  logic [PAGE_BITS-1:0] page_r;
  logic                 in_acc;
  logic                 commit;
  logic                 scan_done;
  lru_pkg::scan_t       res;
  lru_pkg::upd_t        upd;

  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    commit    = 1'b0;
    case (state_r)
      lru_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = lru_pkg::ST_SCAN;
        end
      end
      lru_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = lru_pkg::ST_COMMIT;
        end
      end
      lru_pkg::ST_COMMIT: begin
        // wait for the output register to be free
        if (!out_tvalid || out_tready) begin
          commit    = 1'b1;
          state_nxt = lru_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lru_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lru_pkg::ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      page_r <= in_tdata[PAGE_BITS-1:0];
    end
  end

  // Decision from the end of the chain: hit, else first empty, else LRU victim
  always_comb begin
    upd         = '0;
    upd.en      = commit;
    upd.page    = PW'(page_r);
    if (res.hit) begin
      upd.idx   = res.hit_idx;
      upd.limit = res.hit_rank;
    end else if (res.has_empty) begin
      upd.idx     = res.empty_idx;
      upd.age_all = 1'b1;
      upd.fill    = 1'b1;
    end else begin
      upd.idx     = res.victim_idx;
      upd.age_all = 1'b1;
      upd.fill    = 1'b1;
    end
  end

  // ---- cell chain ----
  logic           tok   [MAX_FRAMES+1];
  lru_pkg::scan_t scan  [MAX_FRAMES+1];

  assign tok[0]    = start_r;
  assign scan[0]   = '0;
  assign scan_done = tok[MAX_FRAMES];
  assign res       = scan[MAX_FRAMES];

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    lru_cell #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .IDX        (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .act      (cell_act[g]),
      .clr      (cfg_wr),
      .page_req (page_r),
      .tok_in   (tok[g]),
      .scan_in  (scan[g]),
      .tok_out  (tok[g+1]),
      .scan_out (scan[g+1]),
      .upd      (upd)
    );
  end

  // ---- output register ----
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r;
  logic [FW-1:0]        out_frame_r;
  logic                 out_ev_r;
  logic [PAGE_BITS-1:0] out_evp_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r   <= res.hit;
      out_frame_r <= FW'(upd.idx);   // frame number kept to three bits
      out_ev_r    <= !res.hit && !res.has_empty;
      out_evp_r   <= (!res.hit && !res.has_empty) ? res.victim_page[PAGE_BITS-1:0] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = OUT_W'({out_evp_r, out_ev_r, out_frame_r});

endmodule

@@ hw/rtl/lru_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for lru_page_replacement, attached with bind.
// Depends on lru_pkg.
module lru_chk #(
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF,
  localparam int OUT_W = ((lru_pkg::FRAME_W + 1 + PAGE_BITS + 7) / 8) * 8
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [OUT_W-1:0]               out_tdata,
  input logic                           out_tuser,
  input logic                           cfg_pready
);

  localparam int EV = lru_pkg::FRAME_W;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[EV])
    else $error("hit reported together with eviction");

  // no eviction means evicted page reads zero
  a_evp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[EV] |-> out_tdata[EV+PAGE_BITS:EV+1] == '0)
    else $error("evicted page nonzero without eviction");

  // one request in flight: after an accepted request, no new one next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in flight");

  // register port never waits
  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready dropped");

endmodule

bind lru_page_replacement lru_chk #(.PAGE_BITS(PAGE_BITS)) u_lru_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tvalid   (in_tvalid),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .out_tuser   (out_tuser),
  .cfg_pready  (cfg_pready)
);
